### design/slsd_pkg.sv
// ----------------------------------------------------------------------------
// slsd_pkg
// Shared types and constants of the static list symmetric difference block.
// ----------------------------------------------------------------------------
package slsd_pkg;

  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int NODE_W   = 10;

  // Request command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INIT   = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TOGGLE = 2'd2,
    CMD_LOCATE = 2'd3
  } cmd_e;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,       // hold
    OP_START,      // latch request, read tail link (head link for locate)
    OP_SWEEP,      // write one free chain link
    OP_INIT_DONE,  // last free chain link, set head/tail/free, result
    OP_A_END,      // take tail link as end, read free node link
    OP_END_LD,     // take tail link as end, read head link
    OP_FREE_RD,    // read free node link
    OP_FIRST,      // first node of walk, read its link and value
    OP_ADV,        // step walk to next node
    OP_UNLINK,     // bypass found node
    OP_INS_A,      // pop free node, write its value and link
    OP_INS_B,      // hook free node after tail, result
    OP_REM,        // return found node to free chain, result
    OP_LOC_HIT,    // locate found, result
    OP_FAIL_FREE,  // no list or no free node, result
    OP_FAIL_LOC    // locate miss, result
  } dp_op_e;

  // Datapath flags seen by the controller
  typedef struct packed {
    logic head_zero;   // no list set up
    logic free_zero;   // free chain empty
    logic link_stop;   // fetched link ends the walk
    logic steps_last;  // walk bound reached
    logic val_match;   // fetched value equals request value
    logic sweep_last;  // sweep at last node
  } dp_status_t;

endpackage

### design/static_list_symmetric_difference.sv
// Init: one free chain link written per cycle. Toggle and locate walk the list,
//   visiting at most NODES nodes.
// Throughput: one request at a time; the walk reads one node per cycle from the
//   link and value memories, and the next request is taken the cycle after the result.
// Reset: no list (head 0), result empty; the node memories are not cleared, and
//   the free chain is built by the init command.
// ----------------------------------------------------------------------------
// static_list_symmetric_difference
// Static linked list in a node memory holding the symmetric difference of two
// value sets, with a free chain, toggle and locate walks.
// ----------------------------------------------------------------------------
module static_list_symmetric_difference #(
  parameter int NODES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [9:0] node_index, [15:10] zero
  output logic [2:0]  m_axis_tuser_o    // [1:0] status, [2] removed
);

  slsd_pkg::dp_op_e     dp_op;
  slsd_pkg::dp_status_t dp_status;
  logic [slsd_pkg::STATUS_W-1:0] res_status;
  logic [slsd_pkg::NODE_W-1:0]   res_node;
  logic                          res_removed;

  // Sequencer
  slsd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .cmd_i     (s_axis_tuser_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .status_i  (dp_status),
    .op_o      (dp_op)
  );

  // Node memories and pointers
  slsd_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (dp_op),
    .cmd_i         (s_axis_tuser_i),
    .val_i         (s_axis_tdata_i),
    .status_o      (dp_status),
    .res_status_o  (res_status),
    .res_node_o    (res_node),
    .res_removed_o (res_removed)
  );

  assign m_axis_tdata_o = {6'b0, res_node};
  assign m_axis_tuser_o = {res_removed, res_status};

`ifndef SYNTHESIS
  // A new result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_op == slsd_pkg::OP_INIT_DONE || dp_op == slsd_pkg::OP_INS_B ||
     dp_op == slsd_pkg::OP_REM || dp_op == slsd_pkg::OP_LOC_HIT ||
     dp_op == slsd_pkg::OP_FAIL_FREE || dp_op == slsd_pkg::OP_FAIL_LOC)
    |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result issued while output slot occupied");

  // A request keeps the block busy for at least the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request taken without sequencing");

  // A removal always names a real node with ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[2])
    |-> (m_axis_tuser_o[1:0] == slsd_pkg::ST_OK && m_axis_tdata_o[9:0] != 10'd0))
    else $error("removal result without node");
`endif

endmodule

### design/slsd_dp.sv
// ----------------------------------------------------------------------------
// slsd_dp
// Node memories, list pointers, walk registers and result payload.
// ----------------------------------------------------------------------------
module slsd_dp #(
  parameter int NODES = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  slsd_pkg::dp_op_e                  op_i,
  input  logic [slsd_pkg::CMD_W-1:0]        cmd_i,
  input  logic signed [slsd_pkg::VALUE_W-1:0] val_i,
  output slsd_pkg::dp_status_t              status_o,
  output logic [slsd_pkg::STATUS_W-1:0]     res_status_o,
  output logic [slsd_pkg::NODE_W-1:0]       res_node_o,
  output logic                              res_removed_o
);

  localparam int IW = $clog2(NODES);
  localparam logic [IW-1:0] LastIdx = IW'(NODES - 1);
  localparam logic [IW-1:0] ZeroIdx = '0;
  localparam logic [IW-1:0] OneIdx  = IW'(1);
  localparam logic [IW-1:0] TwoIdx  = IW'(2);

  // Node memories
  logic [IW-1:0]                       link_mem [NODES];
  logic signed [slsd_pkg::VALUE_W-1:0] value_mem [NODES];

  // Control state
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [IW-1:0] free_q, free_d;

  // Walk and request registers
  logic [IW-1:0] end_q, end_d;
  logic [IW-1:0] p_q, p_d;
  logic [IW-1:0] k_q, k_d;
  logic [IW-1:0] steps_q, steps_d;
  logic [IW-1:0] nf_q, nf_d;
  logic signed [slsd_pkg::VALUE_W-1:0] val_q, val_d;
  slsd_pkg::cmd_e cmd_q, cmd_d;

  // Result payload
  logic [slsd_pkg::STATUS_W-1:0] rs_q, rs_d;
  logic [slsd_pkg::NODE_W-1:0]   rn_q, rn_d;
  logic                          rr_q, rr_d;

  // Memory ports
  logic                                rd_en;
  logic [IW-1:0]                       rd_addr;
  logic [IW-1:0]                       rd_link_q;
  logic signed [slsd_pkg::VALUE_W-1:0] rd_val_q;
  logic                                lk_we;
  logic [IW-1:0]                       lk_waddr;
  logic [IW-1:0]                       lk_wdata;
  logic                                vl_we;
  logic [IW-1:0]                       sweep_link;

  // Free chain link for the sweep: node 1 is the list head and ends, the free chain runs from node 2 to the last node
  assign sweep_link = (k_q == OneIdx || k_q == LastIdx) ? ZeroIdx : IW'(k_q + OneIdx);

  // Operation decode
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    free_d   = free_q;
    end_d    = end_q;
    p_d      = p_q;
    k_d      = k_q;
    steps_d  = steps_q;
    nf_d     = nf_q;
    val_d    = val_q;
    cmd_d    = cmd_q;
    rs_d     = rs_q;
    rn_d     = rn_q;
    rr_d     = rr_q;
    rd_en    = 1'b0;
    rd_addr  = rd_link_q;
    lk_we    = 1'b0;
    lk_waddr = k_q;
    lk_wdata = sweep_link;
    vl_we    = 1'b0;
    case (op_i)
      slsd_pkg::OP_START: begin
        val_d   = val_i;
        cmd_d   = slsd_pkg::cmd_e'(cmd_i);
        k_d     = OneIdx;
        rd_en   = 1'b1;
        rd_addr = (slsd_pkg::cmd_e'(cmd_i) == slsd_pkg::CMD_LOCATE) ? head_q : tail_q;
      end
      slsd_pkg::OP_SWEEP: begin
        lk_we = 1'b1;
        k_d   = IW'(k_q + OneIdx);
      end
      slsd_pkg::OP_INIT_DONE: begin
        lk_we  = 1'b1;
        head_d = OneIdx;
        tail_d = OneIdx;
        free_d = TwoIdx;
        rs_d   = slsd_pkg::ST_OK;
        rn_d   = slsd_pkg::NODE_W'(OneIdx);
        rr_d   = 1'b0;
      end
      slsd_pkg::OP_A_END: begin
        end_d   = rd_link_q;
        rd_en   = 1'b1;
        rd_addr = free_q;
      end
      slsd_pkg::OP_END_LD: begin
        end_d   = rd_link_q;
        p_d     = head_q;
        rd_en   = 1'b1;
        rd_addr = head_q;
      end
      slsd_pkg::OP_FREE_RD: begin
        rd_en   = 1'b1;
        rd_addr = free_q;
      end
      slsd_pkg::OP_FIRST: begin
        k_d     = rd_link_q;
        steps_d = ZeroIdx;
        rd_en   = 1'b1;
      end
      slsd_pkg::OP_ADV: begin
        p_d     = k_q;
        k_d     = rd_link_q;
        steps_d = IW'(steps_q + OneIdx);
        rd_en   = 1'b1;
      end
      slsd_pkg::OP_UNLINK: begin
        lk_we    = 1'b1;
        lk_waddr = p_q;
        lk_wdata = rd_link_q;
      end
      slsd_pkg::OP_INS_A: begin
        nf_d     = rd_link_q;
        lk_we    = 1'b1;
        lk_waddr = free_q;
        lk_wdata = end_q;
        vl_we    = 1'b1;
      end
      slsd_pkg::OP_INS_B: begin
        lk_we    = 1'b1;
        lk_waddr = tail_q;
        lk_wdata = free_q;
        free_d   = nf_q;
        if (cmd_q == slsd_pkg::CMD_APPEND) begin
          tail_d = free_q;
        end
        rs_d = slsd_pkg::ST_OK;
        rn_d = slsd_pkg::NODE_W'(free_q);
        rr_d = 1'b0;
      end
      slsd_pkg::OP_REM: begin
        lk_we    = 1'b1;
        lk_waddr = k_q;
        lk_wdata = free_q;
        free_d   = k_q;
        if (tail_q == k_q) begin
          tail_d = p_q;
        end
        rs_d = slsd_pkg::ST_OK;
        rn_d = slsd_pkg::NODE_W'(k_q);
        rr_d = 1'b1;
      end
      slsd_pkg::OP_LOC_HIT: begin
        rs_d = slsd_pkg::ST_OK;
        rn_d = slsd_pkg::NODE_W'(k_q);
        rr_d = 1'b0;
      end
      slsd_pkg::OP_FAIL_FREE: begin
        rs_d = slsd_pkg::ST_NO_FREE;
        rn_d = '0;
        rr_d = 1'b0;
      end
      slsd_pkg::OP_FAIL_LOC: begin
        rs_d = slsd_pkg::ST_NOT_FOUND;
        rn_d = '0;
        rr_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // List pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      free_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      free_q <= free_d;
    end
  end

  // Walk, request and result registers
  always_ff @(posedge clk_i) begin
    end_q   <= end_d;
    p_q     <= p_d;
    k_q     <= k_d;
    steps_q <= steps_d;
    nf_q    <= nf_d;
    val_q   <= val_d;
    cmd_q   <= cmd_d;
    rs_q    <= rs_d;
    rn_q    <= rn_d;
    rr_q    <= rr_d;
  end

  // Link memory, registered read
  always_ff @(posedge clk_i) begin
    if (lk_we) begin
      link_mem[lk_waddr] <= lk_wdata;
    end
    if (rd_en) begin
      rd_link_q <= link_mem[rd_addr];
    end
  end

  // Value memory, registered read at the same node
  always_ff @(posedge clk_i) begin
    if (vl_we) begin
      value_mem[free_q] <= val_q;
    end
    if (rd_en) begin
      rd_val_q <= value_mem[rd_addr];
    end
  end

  // Flags to the controller
  assign status_o.head_zero  = (head_q == ZeroIdx);
  assign status_o.free_zero  = (free_q == ZeroIdx);
  assign status_o.link_stop  = (rd_link_q == ZeroIdx) ||
                               (cmd_q == slsd_pkg::CMD_TOGGLE && rd_link_q == end_q);
  assign status_o.steps_last = (steps_q == LastIdx);
  assign status_o.val_match  = (rd_val_q == val_q);
  assign status_o.sweep_last = (k_q == LastIdx);

  assign res_status_o  = rs_q;
  assign res_node_o    = rn_q;
  assign res_removed_o = rr_q;

endmodule

### design/slsd_ctrl.sv
// ----------------------------------------------------------------------------
// slsd_ctrl
// Request sequencer: steps the datapath through each command and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module slsd_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_valid_i,
  input  logic [slsd_pkg::CMD_W-1:0] cmd_i,
  output logic                       s_ready_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  input  slsd_pkg::dp_status_t       status_i,
  output slsd_pkg::dp_op_e           op_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SWEEP,
    S_A_END,
    S_T_END,
    S_FIRST,
    S_CHK,
    S_INS_A,
    S_INS_B,
    S_REM,
    S_LOC_HIT,
    S_FAIL_FREE,
    S_FAIL_LOC
  } state_e;

  state_e         state_q, state_d;
  slsd_pkg::cmd_e cmd_q, cmd_d;
  logic           m_valid_q, m_valid_d;
  logic           slot_free;
  logic           res_issue;
  logic           accept;

  assign s_ready_o = (state_q == S_IDLE);
  assign accept    = s_valid_i && s_ready_o;
  assign slot_free = !m_valid_q || m_ready_i;

  // Next state and datapath operation
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    op_o      = slsd_pkg::OP_NONE;
    res_issue = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_o  = slsd_pkg::OP_START;
          cmd_d = slsd_pkg::cmd_e'(cmd_i);
          case (slsd_pkg::cmd_e'(cmd_i))
            slsd_pkg::CMD_INIT:   state_d = S_SWEEP;
            slsd_pkg::CMD_APPEND: state_d = status_i.head_zero ? S_FAIL_FREE : S_A_END;
            slsd_pkg::CMD_TOGGLE: state_d = status_i.head_zero ? S_FAIL_FREE : S_T_END;
            slsd_pkg::CMD_LOCATE: state_d = status_i.head_zero ? S_FAIL_LOC : S_FIRST;
            default:              state_d = S_IDLE;
          endcase
        end
      end
      S_SWEEP: begin
        if (!status_i.sweep_last) begin
          op_o = slsd_pkg::OP_SWEEP;
        end else if (slot_free) begin
          op_o      = slsd_pkg::OP_INIT_DONE;
          res_issue = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_A_END: begin
        if (status_i.free_zero) begin
          state_d = S_FAIL_FREE;
        end else begin
          op_o    = slsd_pkg::OP_A_END;
          state_d = S_INS_A;
        end
      end
      S_T_END: begin
        op_o    = slsd_pkg::OP_END_LD;
        state_d = S_FIRST;
      end
      S_FIRST: begin
        if (!status_i.link_stop) begin
          op_o    = slsd_pkg::OP_FIRST;
          state_d = S_CHK;
        end else if (cmd_q == slsd_pkg::CMD_LOCATE) begin
          state_d = S_FAIL_LOC;
        end else if (status_i.free_zero) begin
          state_d = S_FAIL_FREE;
        end else begin
          op_o    = slsd_pkg::OP_FREE_RD;
          state_d = S_INS_A;
        end
      end
      S_CHK: begin
        if (status_i.val_match) begin
          if (cmd_q == slsd_pkg::CMD_LOCATE) begin
            state_d = S_LOC_HIT;
          end else begin
            op_o    = slsd_pkg::OP_UNLINK;
            state_d = S_REM;
          end
        end else if (!status_i.link_stop && !status_i.steps_last) begin
          op_o = slsd_pkg::OP_ADV;
        end else if (cmd_q == slsd_pkg::CMD_LOCATE) begin
          state_d = S_FAIL_LOC;
        end else if (status_i.free_zero) begin
          state_d = S_FAIL_FREE;
        end else begin
          op_o    = slsd_pkg::OP_FREE_RD;
          state_d = S_INS_A;
        end
      end
      S_INS_A: begin
        op_o    = slsd_pkg::OP_INS_A;
        state_d = S_INS_B;
      end
      S_INS_B: begin
        if (slot_free) begin
          op_o      = slsd_pkg::OP_INS_B;
          res_issue = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_REM: begin
        if (slot_free) begin
          op_o      = slsd_pkg::OP_REM;
          res_issue = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_LOC_HIT: begin
        if (slot_free) begin
          op_o      = slsd_pkg::OP_LOC_HIT;
          res_issue = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_FAIL_FREE: begin
        if (slot_free) begin
          op_o      = slsd_pkg::OP_FAIL_FREE;
          res_issue = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_FAIL_LOC: begin
        if (slot_free) begin
          op_o      = slsd_pkg::OP_FAIL_LOC;
          res_issue = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result valid: set on a new result, cleared once taken
  always_comb begin
    if (res_issue) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cmd_q     <= slsd_pkg::CMD_INIT;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmd_q     <= cmd_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;

endmodule
